>>> src/multi_value_string_pad_trim_macros.svh
// Assertion macros for the multi-valued string pad trimmer.
// Used by the top level; depends on nothing else.
`ifndef MULTI_VALUE_STRING_PAD_TRIM_MACROS_SVH
`define MULTI_VALUE_STRING_PAD_TRIM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MVSPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvspt same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MVSPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvspt next-cycle check failed");

`endif

>>> src/mvspt_pkg.sv
// Package for the multi-valued string pad trimmer: word types, config struct
// and fixed constants. No dependencies.
`timescale 1ns / 1ps

package mvspt_pkg;

    localparam logic [7:0] SEPARATOR_BYTE = 8'h5C;
    localparam int         CFG_IDX_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPLIT      = 2'd0,
        CFG_TRIM_LEAD  = 2'd1,
        CFG_TRIM_TRAIL = 2'd2,
        CFG_PAD_BYTE   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] pads_before;
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
        logic       run_overflow;
    } t_out_word;

    typedef struct packed {
        logic       split_components;
        logic       trim_leading;
        logic       trim_trailing;
        logic [7:0] pad_byte;
    } t_cfg;

endpackage

>>> src/mvspt_core.sv
// Per-byte trim logic and component state (start flag, held pad count).
// Depends on mvspt_pkg.
`timescale 1ns / 1ps

module mvspt_core import mvspt_pkg::*; #(
    parameter logic [7:0] RUN_CAP = 8'd255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    logic       r_at_start;
    logic [7:0] r_held;
    logic       n_at_start;
    logic [7:0] n_held;
    logic       is_sep;
    logic       is_pad;

    assign is_sep = i_cfg.split_components && (i_word.in_byte == SEPARATOR_BYTE);
    assign is_pad = (i_word.in_byte == i_cfg.pad_byte);

    always_comb begin
        o_result            = '0;
        o_result.out_last   = i_word.in_last;
        n_at_start          = r_at_start;
        n_held              = r_held;
        if (is_sep) begin
            o_result.out_byte  = i_word.in_byte;
            o_result.out_valid = 1'b1;
            n_held             = '0;
            n_at_start         = 1'b1;
        end else if (is_pad && i_cfg.trim_leading && r_at_start) begin
            // Leading pad is simply dropped.
            n_at_start = r_at_start;
        end else if (is_pad && i_cfg.trim_trailing) begin
            // Pad may turn out to be trailing, so hold it back as a count.
            if (r_held < RUN_CAP) begin
                n_held = r_held + 8'd1;
            end else begin
                o_result.run_overflow = 1'b1;
            end
            n_at_start = 1'b0;
        end else begin
            o_result.pads_before = r_held;
            o_result.out_byte    = i_word.in_byte;
            o_result.out_valid   = 1'b1;
            n_held               = '0;
            n_at_start           = 1'b0;
        end
        if (i_word.in_last) begin
            n_held     = '0;
            n_at_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_held     <= '0;
        end else if (i_accept) begin
            r_at_start <= n_at_start;
            r_held     <= n_held;
        end
    end

endmodule

>>> src/multi_value_string_pad_trim.sv
// Top level of the multi-valued string pad trimmer: config registers,
// output register with skid stage, assertions.
// Depends on mvspt_pkg, mvspt_core and multi_value_string_pad_trim_macros.svh.
//
// Usage: one string byte per word on the input channel (i_in_valid,
// o_in_stall, i_in_data), one result word per input word on the output
// channel (o_out_valid, i_out_stall, o_out_data). A result word carries the
// held pad count to emit, the byte itself if it is kept, a copy of the last
// flag and a flag for a saturated pad run.
// Each accepted word is registered in the output register, or in the skid
// stage when the output is held. Throughput is one word per cycle while
// the receiver does not stall. Registers are written through i_cfg_valid
// and o_cfg_ready (always ready), i_cfg_index and i_cfg_data; the user must
// write them only while no string is in flight. The block does not check it.
// Reset clears the component state and restores the register defaults
// (split on, both trims on, pad byte space); the output is empty.
// When the receiver stalls, one more word is taken into the skid stage and
// then o_in_stall rises until the output drains.
`timescale 1ns / 1ps

`include "multi_value_string_pad_trim_macros.svh"

module multi_value_string_pad_trim import mvspt_pkg::*; #(
    parameter int MAX_PAD_RUN = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam logic [7:0] RUN_CAP = (MAX_PAD_RUN > 255) ? 8'd255 : 8'(MAX_PAD_RUN);

    t_cfg      r_cfg;
    t_out_word r_out;
    t_out_word r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_word result;
    logic      in_accept;
    logic      out_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_fire    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split_components <= 1'b1;
            r_cfg.trim_leading     <= 1'b1;
            r_cfg.trim_trailing    <= 1'b1;
            r_cfg.pad_byte         <= 8'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SPLIT:      r_cfg.split_components <= i_cfg_data[0];
                CFG_TRIM_LEAD:  r_cfg.trim_leading     <= i_cfg_data[0];
                CFG_TRIM_TRAIL: r_cfg.trim_trailing    <= i_cfg_data[0];
                CFG_PAD_BYTE:   r_cfg.pad_byte         <= i_cfg_data;
                default:        r_cfg                  <= r_cfg;
            endcase
        end
    end

    mvspt_core #(
        .RUN_CAP (RUN_CAP)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Output register plus one skid word so the input can take one more word
    // after the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (!r_out_valid || out_fire) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    `MVSPT_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `MVSPT_ASSERT_IMP(a_drop_is_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.out_valid, o_out_data.pads_before == 8'd0 && o_out_data.out_byte == 8'd0)
    `MVSPT_ASSERT_IMP(a_ovf_not_kept, i_clk, i_rst_n, o_out_valid && o_out_data.run_overflow, !o_out_data.out_valid)
    `MVSPT_ASSERT_NXT(a_stall_to_skid, i_clk, i_rst_n, in_accept && r_out_valid && i_out_stall, r_skid_valid)

endmodule
